// File: design/u64_to_decimal_ascii_top_assert.svh
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii_top_assert.svh
// Assertion macros for the decimal ASCII converter.
// ----------------------------------------------------------------------------
`ifndef U64_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define U64_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef SYNTH
`define U2D_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define U2D_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);
`else
`define U2D_ASSERT(lbl, ck, rs, prop, msg)
`define U2D_NEVER(lbl, ck, rs, cond, msg)
`endif

`endif

// File: design/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared types and constants of the decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 20;

  localparam int VALUE_FIELD_W = 64;
  localparam int ROOM_W        = 8;
  localparam int CHAR_W        = 6;
  localparam int DIGIT_W       = 4;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       bit_in;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/u64_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii_top
// Unsigned binary to decimal ASCII converter, one digit character per beat.
// ----------------------------------------------------------------------------
// Input beat (s_axis): value in tdata[63:0], free room in tdata[71:64].
// Output beats (m_axis): one ASCII digit each, most significant first, no
// leading zeros; zero gives "0". At most room characters leave; tlast marks
// the final one. Room of zero gives no output beat.
// Steps per item: the beat is taken while idle, then the value is shifted
// with add-3 through the row of BCD cells (one input bit per cycle), then
// leading zero digits are skipped (up to MAX_DIGITS-1), then the characters
// are delivered, one per accepted output beat; a short room cuts them.
// The row of cells is shared, so one item is in work at a time;
// s_axis_tready is high only while idle and out of reset.
// A stalled receiver holds the current character and the whole row; nothing
// is lost. Reset returns to idle and drops any item in progress.
// ----------------------------------------------------------------------------
`default_nettype none

`include "u64_to_decimal_ascii_top_assert.svh"

module u64_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = u2d_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = u2d_pkg::MAX_DIGITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [u2d_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // value[63:0], room[71:64]
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [u2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // digit_char[5:0], zero pad
  output logic                                m_axis_tlast
);
  import u2d_pkg::*;

  localparam int BW = $clog2(VALUE_WIDTH + 1);
  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam logic [BW-1:0] BITS_INIT  = BW'(VALUE_WIDTH);
  localparam logic [LW-1:0] DIGIT_INIT = LW'(MAX_DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] vreg;
  logic [BW-1:0]          bits;
  logic [LW-1:0]          left;
  logic [ROOM_W-1:0]      room;
  logic                   ovf;

  cell_ctrl_t             ctrl;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   carry_out;
  logic                   in_beat;
  logic                   out_beat;
  logic                   skip;

  u2d_chain #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit),
    .carry_out (carry_out)
  );

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = (state == ST_EMIT) && !rst;
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign skip     = !ovf && (top_digit == '0) && (left != LW'(1));

  assign m_axis_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, CHAR_ZERO + CHAR_W'(top_digit)};
  assign m_axis_tlast = (room == ROOM_W'(1)) || (left == LW'(1));

  always_comb begin
    ctrl.bit_in = vreg[VALUE_WIDTH-1];
    ctrl.mode   = CELL_HOLD;
    unique case (state)
      ST_IDLE: if (in_beat) ctrl.mode = CELL_CLEAR;
      ST_CONV: ctrl.mode = CELL_DABBLE;
      ST_SKIP: if (skip) ctrl.mode = CELL_SHIFT;
      ST_EMIT: if (out_beat) ctrl.mode = CELL_SHIFT;
      default: ctrl.mode = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            vreg  <= s_axis_tdata[VALUE_WIDTH-1:0];
            room  <= s_axis_tdata[VALUE_FIELD_W +: ROOM_W];
            bits  <= BITS_INIT;
            left  <= DIGIT_INIT;
            ovf   <= 1'b0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          vreg <= vreg << 1;
          bits <= bits - BW'(1);
          if (carry_out) ovf <= 1'b1;
          if (bits == BW'(1)) state <= ST_SKIP;
        end
        ST_SKIP: begin
          if (skip) begin
            left <= left - LW'(1);
          end else if (room == '0) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_beat) begin
            left <= left - LW'(1);
            room <= room - ROOM_W'(1);
            if (m_axis_tlast) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `U2D_ASSERT(a_digit_bcd, clk, rst, m_axis_tvalid |-> (top_digit <= 4'd9), "digit out of range")
  `U2D_NEVER(a_emit_counts, clk, rst, (state == ST_EMIT) && ((room == '0) || (left == '0)), "emit with empty count")
  `U2D_ASSERT(a_start_conv, clk, rst, in_beat |=> (state == ST_CONV), "accepted item did not start")
  `U2D_ASSERT(a_last_idle, clk, rst, (out_beat && m_axis_tlast) |=> (state == ST_IDLE), "no idle after last beat")

endmodule

`default_nettype wire

// File: design/u2d_cell.sv
// ----------------------------------------------------------------------------
// u2d_cell
// One BCD digit: add-3 and shift while converting, plain shift while skipping or emitting.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_cell (
  input  wire                           clk,
  input  u2d_pkg::cell_mode_t           mode,
  input  wire                           carry_in,
  input  wire [u2d_pkg::DIGIT_W-1:0]    digit_in,
  output logic [u2d_pkg::DIGIT_W-1:0]   digit,
  output logic                          carry_out
);
  import u2d_pkg::*;

  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit >= DABBLE_LIMIT) ? digit + DABBLE_ADD : digit;
  end

  assign carry_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    unique case (mode)
      CELL_CLEAR:  digit <= '0;
      CELL_DABBLE: digit <= {adj[DIGIT_W-2:0], carry_in};
      CELL_SHIFT:  digit <= digit_in;
      default:     digit <= digit;
    endcase
  end

endmodule

`default_nettype wire

// File: design/u2d_chain.sv
// ----------------------------------------------------------------------------
// u2d_chain
// Row of BCD cells, least significant digit at index zero.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_chain #(
  parameter int MAX_DIGITS = u2d_pkg::MAX_DIGITS_DEF
) (
  input  wire                           clk,
  input  u2d_pkg::cell_ctrl_t           ctrl,
  output logic [u2d_pkg::DIGIT_W-1:0]   top_digit,
  output logic                          carry_out
);
  import u2d_pkg::*;

  logic [DIGIT_W-1:0] digit   [MAX_DIGITS];
  logic [DIGIT_W-1:0] dig_in  [MAX_DIGITS];
  logic               carry   [MAX_DIGITS+1];

  assign carry[0] = ctrl.bit_in;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign dig_in[i] = '0;
    end else begin : g_rest
      assign dig_in[i] = digit[i-1];
    end

    u2d_cell u_cell (
      .clk       (clk),
      .mode      (ctrl.mode),
      .carry_in  (carry[i]),
      .digit_in  (dig_in[i]),
      .digit     (digit[i]),
      .carry_out (carry[i+1])
    );
  end

  assign top_digit = digit[MAX_DIGITS-1];
  assign carry_out = carry[MAX_DIGITS];

endmodule

`default_nettype wire

// File: test/u64_to_decimal_ascii_top_tb.sv
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii_top_tb
// Self-checking bench for the 64-bit binary to decimal ASCII converter.
// Every accepted value/room beat is expanded here into the digit characters
// it should produce; each output beat is checked against the oldest one.
// Directed corners first, then random values of every magnitude under three
// idle profiles, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module u64_to_decimal_ascii_top_tb;
  import u2d_pkg::*;

  localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
  localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 342;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4 * (VALUE_WIDTH + MAX_DIGITS);
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } ascii_beat_t;

  class digit_scoreboard;
    ascii_beat_t pending_chars[$];
    int          errors = 0;

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function int outstanding();
      return pending_chars.size();
    endfunction

    // Expand one value into its leading-zero-free decimal text, cut to room.
    function void note_value(logic [VALUE_FIELD_W-1:0] value, logic [ROOM_W-1:0] room);
      logic [VALUE_FIELD_W-1:0] v;
      logic [VALUE_FIELD_W-1:0] mask;
      logic [DIGIT_W-1:0]       lsd_first[MAX_DIGITS];
      int                       n;
      int                       emit;
      ascii_beat_t              beat;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      v = value & mask;
      n = 0;
      if (v == 0) begin
        lsd_first[0] = '0;
        n = 1;
      end else begin
        while (v != 0 && n < MAX_DIGITS) begin
          lsd_first[n] = DIGIT_W'(v % 64'd10);
          v = v / 64'd10;
          n++;
        end
      end
      emit = (int'(room) < n) ? int'(room) : n;
      for (int k = 0; k < emit; k++) begin
        beat.digit_char = CHAR_ZERO + CHAR_W'(lsd_first[n - 1 - k]);
        beat.last       = (k + 1 == emit);
        pending_chars.push_back(beat);
      end
    endfunction

    task check_char(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      ascii_beat_t exp_beat;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tdata=%0d tlast=%0b", tdata, tlast));
      end else begin
        exp_beat = pending_chars.pop_front();
        if (tdata[CHAR_W-1:0] !== exp_beat.digit_char)
          report_mismatch($sformatf("digit_char %0d, expected %0d",
                                    tdata[CHAR_W-1:0], exp_beat.digit_char));
        if (tlast !== exp_beat.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", tlast, exp_beat.last));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  digit_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int cycle_count   = 0;

  u64_to_decimal_ascii_top #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: checks accepted beats, then picks tready for the next cycle.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_char(m_axis_tdata, m_axis_tlast);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_value(logic [VALUE_FIELD_W-1:0] value, logic [ROOM_W-1:0] room);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {room, value};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_value(value, room);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(5, 0))
      0:       return full;
      1, 2:    return full >> $urandom_range(63, 0);
      3:       return pow10($urandom_range(19, 0)) + 64'($urandom_range(2, 0)) - 64'd1;
      4:       return 64'($urandom_range(20, 0));
      default: return ~64'd0 - 64'($urandom_range(1000, 0));
    endcase
  endfunction

  function automatic logic [ROOM_W-1:0] pick_room();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return ROOM_W'($urandom_range(255, 0));
      default: return ROOM_W'($urandom_range(21, 1));
    endcase
  endfunction

  initial begin : stimulus
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: zero, all ones, digit-count boundaries, room cut and no room
    send_value(64'd0, 8'd20);
    send_value(64'd0, 8'd0);
    send_value(64'd0, 8'd1);
    send_value(~64'd0, 8'd20);
    send_value(~64'd0, 8'd255);
    send_value(~64'd0, 8'd19);
    send_value(~64'd0, 8'd1);
    send_value(~64'd0, 8'd0);
    send_value(64'd9, 8'd1);
    send_value(64'd10, 8'd1);
    send_value(64'd99, 8'd2);
    send_value(64'd100, 8'd3);
    send_value(64'd1, 8'd128);
    send_value(pow10(19) - 64'd1, 8'd19);
    send_value(pow10(19), 8'd20);
    send_value(pow10(19), 8'd5);
    send_value(64'h8000_0000_0000_0000, 8'd21);
    send_value(64'hAAAA_AAAA_AAAA_AAAA, 8'd10);
    send_value(64'h5555_5555_5555_5555, 8'd85);
    send_value(64'd123, 8'd2);
    send_value(64'd1234567890, 8'd170);
    wait_for_drain();

    // long receiver hold-off with the sender pushing back to back
    @(posedge clk);
    hold_requests = hold_requests + 1;
    for (int i = 0; i < 6; i++) send_value(pick_value(), ROOM_W'($urandom_range(20, 1)));
    wait_for_drain();
    @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 26;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == 0) begin
        send_idle_pct = 26;
        recv_idle_pct = 51;
      end
      send_value(pick_value(), pick_room());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
